>>> hdl/coalescing_interval_set_unit_defines.svh
// Assertion macros shared by the interval set unit.
`ifndef COALESCING_INTERVAL_SET_UNIT_DEFINES_SVH
`define COALESCING_INTERVAL_SET_UNIT_DEFINES_SVH

// Same-cycle implication.
`define CIS_ASSERT_SAME(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication.
`define CIS_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> hdl/cis_pkg.sv
package cis_pkg;

   localparam int MAX_INTERVALS_DEF = 64;
   localparam int CMD_W = 3;
   localparam int GRP_W = 64;
   localparam int OBJ_W = 64;

   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_PREV   = 3'd4;

   typedef struct packed {
      logic [GRP_W-1:0] grp;
      logic [OBJ_W-1:0] obj;
   } loc_type;

   typedef struct packed {
      loc_type lo;
      loc_type hi;
   } entry_type;

   typedef struct packed {
      logic below;
      logic overlap;
   } scan_flag_type;

   typedef struct packed {
      logic      found;
      entry_type res;
      loc_type   lo_first;
      loc_type   hi_last;
   } scan_cap_type;

   function automatic logic loc_lt(loc_type a, loc_type b);
      return {a.grp, a.obj} < {b.grp, b.obj};
   endfunction

   // Object carries into group, so the pair acts as one wide number.
   function automatic loc_type loc_succ(loc_type a);
      logic [GRP_W+OBJ_W-1:0] v;
      v = {a.grp, a.obj} + 1'b1;
      return loc_type'(v);
   endfunction

   function automatic loc_type loc_pred(loc_type a);
      logic [GRP_W+OBJ_W-1:0] v;
      v = {a.grp, a.obj} - 1'b1;
      return loc_type'(v);
   endfunction

   function automatic logic loc_is_min(loc_type a);
      return (a.grp == '0) && (a.obj == '0);
   endfunction

   function automatic logic loc_is_max(loc_type a);
      return (a.grp == '1) && (a.obj == '1);
   endfunction

endpackage

>>> hdl/cis_mem.sv
module cis_mem #(
   parameter int DEPTH = cis_pkg::MAX_INTERVALS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  cis_pkg::entry_type       wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output cis_pkg::entry_type       rd_data
);
   import cis_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/cis_scan.sv
module cis_scan (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  logic                         valid,
   input  logic [cis_pkg::CMD_W-1:0]    cmd,
   input  cis_pkg::loc_type             p,
   input  cis_pkg::loc_type             q,
   input  cis_pkg::entry_type           entry,
   output cis_pkg::scan_flag_type       flag,
   output cis_pkg::scan_cap_type        cap
);
   import cis_pkg::*;

   logic      hi_ge_p;
   logic      lo_le_q;
   logic      ov_seen_ff;
   logic      above_seen_ff;
   logic      found_ff;
   entry_type res_ff;
   loc_type   lo_first_ff;
   loc_type   hi_last_ff;

   // Sorted table: entries entirely below p, then overlaps, then entries above q.
   always_comb begin
      hi_ge_p      = !loc_lt(entry.hi, p);
      lo_le_q      = !loc_lt(q, entry.lo);
      flag.below   = !hi_ge_p;
      flag.overlap = hi_ge_p && lo_le_q;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         ov_seen_ff    <= 1'b0;
         above_seen_ff <= 1'b0;
         found_ff      <= 1'b0;
      end else if (valid) begin
         if (flag.overlap) begin
            ov_seen_ff <= 1'b1;
            hi_last_ff <= entry.hi;
            if (!ov_seen_ff) begin
               lo_first_ff <= entry.lo;
               if (cmd == CMD_QUERY) begin
                  found_ff <= 1'b1;
                  res_ff   <= entry;
               end
            end
         end
         // Keep the last entry below for prev.
         if (flag.below && cmd == CMD_PREV) begin
            found_ff <= 1'b1;
            res_ff   <= entry;
         end
         if (!lo_le_q && !above_seen_ff) begin
            above_seen_ff <= 1'b1;
            if (cmd == CMD_NEXT) begin
               found_ff <= 1'b1;
               res_ff   <= entry;
            end
         end
      end
   end

   assign cap = '{found: found_ff, res: res_ff, lo_first: lo_first_ff, hi_last: hi_last_ff};

endmodule

>>> hdl/coalescing_interval_set_unit.sv
// Channel   Ports                         Direction  Handshake
// request   req_command .. req_end_object in         start & !busy
// response  rsp_found .. rsp_table_full   out        rsp_valid, one cycle
//
// Queries make one pass over the table through the single read port of the
// interval memory, one entry a cycle.
// Insert and remove run the scan, then a move of the tail entries (one a
// cycle), then up to two new entries written.
// Reset clears the entry count and the control state; the memory needs no clearing pass.
// The response cannot be stalled; busy drops in the cycle rsp_valid is high.
module coalescing_interval_set_unit #(
   parameter int MAX_INTERVALS = cis_pkg::MAX_INTERVALS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [cis_pkg::CMD_W-1:0]   req_command,
   input  logic [cis_pkg::GRP_W-1:0]   req_start_group,
   input  logic [cis_pkg::OBJ_W-1:0]   req_start_object,
   input  logic [cis_pkg::GRP_W-1:0]   req_end_group,
   input  logic [cis_pkg::OBJ_W-1:0]   req_end_object,
   output logic                        rsp_valid,
   output logic                        rsp_found,
   output logic [cis_pkg::GRP_W-1:0]   rsp_first_group,
   output logic [cis_pkg::OBJ_W-1:0]   rsp_first_object,
   output logic [cis_pkg::GRP_W-1:0]   rsp_last_group,
   output logic [cis_pkg::OBJ_W-1:0]   rsp_last_object,
   output logic                        rsp_table_full
);
   import cis_pkg::*;
`include "coalescing_interval_set_unit_defines.svh"

   localparam int CW = $clog2(MAX_INTERVALS + 1);
   localparam int AW = $clog2(MAX_INTERVALS);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_SCAN, ST_CALC, ST_MOVE, ST_FILL, ST_RESP
   } state_type;

   state_type     state_ff;
   logic [CMD_W-1:0] cmd_ff;
   loc_type       s_ff, e_ff, p_ff, q_ff, pm_ff, ps_ff;
   logic [CW-1:0] count_ff, iss_ff, left_ff, rsrc_ff, below_ff, ov_ff, dist_ff;
   logic [CW-1:0] newcnt_ff;
   logic          rvld_ff, up_ff, full_ff, fidx_ff;
   logic [1:0]    k_ff;
   entry_type     ne0_ff, ne1_ff;

   logic          rsp_valid_ff, rsp_found_ff, rsp_full_ff;
   entry_type     rsp_ent_ff;

   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   entry_type     wr_data, rd_data;
   scan_flag_type flag;
   scan_cap_type  cap;

   // Calculation stage values.
   logic          has_ov, lt_s, gt_e, left_pc, right_pc, rev, is_qry;
   logic [1:0]    k_in;
   entry_type     ne0_in, ne1_in;
   logic [CW:0]   newcnt_in;
   logic [CW-1:0] b_in;
   logic          up_in;

   cis_mem #(.DEPTH(MAX_INTERVALS)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cis_scan u_scan (
      .clock (clock),
      .reset (reset),
      .clear (state_ff == ST_PREP),
      .valid (rvld_ff && state_ff == ST_SCAN),
      .cmd   (cmd_ff),
      .p     (p_ff),
      .q     (q_ff),
      .entry (rd_data),
      .flag  (flag),
      .cap   (cap)
   );

   always_comb begin
      rd_en = 1'b0;
      if (state_ff == ST_SCAN) begin
         rd_en = iss_ff < count_ff;
      end else if (state_ff == ST_MOVE) begin
         rd_en = left_ff != '0;
      end
      rd_addr = iss_ff[AW-1:0];
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = rd_data;
      if (state_ff == ST_MOVE && rvld_ff) begin
         wr_en   = 1'b1;
         wr_addr = up_ff ? AW'(rsrc_ff + 1'b1) : AW'(rsrc_ff - dist_ff);
      end else if (state_ff == ST_FILL) begin
         wr_en   = 1'b1;
         wr_addr = AW'(below_ff + CW'(fidx_ff));
         wr_data = fidx_ff ? ne1_ff : ne0_ff;
      end
   end

   always_comb begin
      rev      = loc_lt(e_ff, s_ff);
      is_qry   = cmd_ff == CMD_QUERY || cmd_ff == CMD_NEXT || cmd_ff == CMD_PREV;
      has_ov   = ov_ff != '0;
      lt_s     = loc_lt(cap.lo_first, s_ff);
      gt_e     = loc_lt(e_ff, cap.hi_last);
      left_pc  = has_ov && lt_s;
      right_pc = has_ov && gt_e;
      ne1_in   = '{lo: ps_ff, hi: cap.hi_last};
      if (cmd_ff == CMD_INSERT) begin
         k_in   = 2'd1;
         ne0_in = '{lo: left_pc ? cap.lo_first : s_ff, hi: right_pc ? cap.hi_last : e_ff};
      end else begin
         k_in   = {1'b0, left_pc} + {1'b0, right_pc};
         ne0_in = left_pc ? '{lo: cap.lo_first, hi: pm_ff} : ne1_in;
      end
      newcnt_in = {1'b0, count_ff} - {1'b0, ov_ff} + (CW+1)'(k_in);
      b_in      = below_ff + ov_ff;
      up_in     = CW'(k_in) > ov_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rvld_ff      <= rd_en;
         rsp_valid_ff <= state_ff == ST_RESP;
         if (rd_en) begin
            rsrc_ff <= iss_ff;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  cmd_ff   <= req_command;
                  s_ff     <= '{grp: req_start_group, obj: req_start_object};
                  e_ff     <= '{grp: req_end_group, obj: req_end_object};
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               pm_ff    <= loc_is_min(s_ff) ? s_ff : loc_pred(s_ff);
               ps_ff    <= loc_is_max(e_ff) ? e_ff : loc_succ(e_ff);
               p_ff     <= (cmd_ff == CMD_INSERT) ?
                           (loc_is_min(s_ff) ? s_ff : loc_pred(s_ff)) : s_ff;
               q_ff     <= (cmd_ff == CMD_INSERT) ?
                           (loc_is_max(e_ff) ? e_ff : loc_succ(e_ff)) :
                           ((cmd_ff == CMD_REMOVE) ? e_ff : s_ff);
               iss_ff   <= '0;
               below_ff <= '0;
               ov_ff    <= '0;
               full_ff  <= 1'b0;
               if (is_qry) begin
                  state_ff <= ST_SCAN;
               end else if (cmd_ff == CMD_INSERT && !rev) begin
                  state_ff <= ST_SCAN;
               end else if (cmd_ff == CMD_REMOVE && !rev && count_ff != '0) begin
                  state_ff <= ST_SCAN;
               end else begin
                  state_ff <= ST_RESP;
               end
            end
            ST_SCAN: begin
               if (rd_en) begin
                  iss_ff <= iss_ff + 1'b1;
               end
               if (rvld_ff) begin
                  below_ff <= below_ff + CW'(flag.below);
                  ov_ff    <= ov_ff + CW'(flag.overlap);
               end
               if (!rd_en && !rvld_ff) begin
                  state_ff <= is_qry ? ST_RESP : ST_CALC;
               end
            end
            ST_CALC: begin
               k_ff      <= k_in;
               ne0_ff    <= ne0_in;
               ne1_ff    <= ne1_in;
               newcnt_ff <= CW'(newcnt_in);
               up_ff     <= up_in;
               dist_ff   <= ov_ff - CW'(k_in);
               fidx_ff   <= 1'b0;
               iss_ff    <= up_in ? count_ff - 1'b1 : b_in;
               left_ff   <= count_ff - b_in;
               if (newcnt_in > (CW+1)'(MAX_INTERVALS)) begin
                  full_ff  <= 1'b1;
                  state_ff <= ST_RESP;
               end else if (!has_ov && k_in == 2'd0) begin
                  state_ff <= ST_RESP;
               end else begin
                  state_ff <= ST_MOVE;
               end
            end
            ST_MOVE: begin
               // Walk down when opening a slot, up when closing a gap.
               if (rd_en) begin
                  iss_ff  <= up_ff ? iss_ff - 1'b1 : iss_ff + 1'b1;
                  left_ff <= left_ff - 1'b1;
               end
               if (!rd_en && !rvld_ff) begin
                  if (k_ff == 2'd0) begin
                     count_ff <= newcnt_ff;
                     state_ff <= ST_RESP;
                  end else begin
                     state_ff <= ST_FILL;
                  end
               end
            end
            ST_FILL: begin
               fidx_ff <= 1'b1;
               if (CW'(fidx_ff) + 1'b1 == CW'(k_ff)) begin
                  count_ff <= newcnt_ff;
                  state_ff <= ST_RESP;
               end
            end
            ST_RESP: begin
               rsp_found_ff <= is_qry && cap.found;
               rsp_ent_ff   <= (is_qry && cap.found) ? cap.res : '0;
               rsp_full_ff  <= full_ff;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy             = state_ff != ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_first_group  = rsp_ent_ff.lo.grp;
   assign rsp_first_object = rsp_ent_ff.lo.obj;
   assign rsp_last_group   = rsp_ent_ff.hi.grp;
   assign rsp_last_object  = rsp_ent_ff.hi.obj;
   assign rsp_table_full   = rsp_full_ff;

   `CIS_ASSERT_SAME(a_count_range, clock, reset, 1'b1,
      count_ff <= CW'(MAX_INTERVALS), "entry count above capacity")
   `CIS_ASSERT_SAME(a_no_write_idle, clock, reset, state_ff == ST_IDLE,
      !wr_en, "memory written while idle")
   `CIS_ASSERT_SAME(a_full_not_found, clock, reset, rsp_valid && rsp_table_full,
      !rsp_found, "refused command reports a found interval")
   `CIS_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy,
      busy && !rsp_valid, "accepted word did not raise busy")

endmodule
